FILE: src/hop_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hop_pkg
// Shared types and constants of the Hopfield associative memory.
// ----------------------------------------------------------------------------
package hop_pkg;

    localparam int CFG_W  = 7;   // neuron_count register width
    localparam int ITER_W = 32;  // iteration counter width

    // per-cycle command broadcast along the cell row
    typedef struct packed {
        logic rd;       // read weight row
        logic wr;       // write weight row
        logic clr;      // write zero
        logic row_bit;  // pattern bit of the addressed row
    } t_cell_ctl;

endpackage

FILE: src/hop_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hop_in_if / hop_out_if
// Valid/ready channels for element items and recalled neuron items.
// ----------------------------------------------------------------------------
interface hop_in_if;
    logic valid;
    logic ready;
    logic action;
    logic value;
    logic new_training_set;

    modport source (output valid, action, value, new_training_set, input ready);
    modport sink   (input valid, action, value, new_training_set, output ready);
endinterface

interface hop_out_if;
    logic        valid;
    logic        ready;
    logic        neuron_value;
    logic        last_of_run;
    logic [31:0] iterations;

    modport source (output valid, neuron_value, last_of_run, iterations, input ready);
    modport sink   (input valid, neuron_value, last_of_run, iterations, output ready);
endinterface

FILE: src/hop_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hop_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hop_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

FILE: src/hop_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hop_cell
// One neuron column: holds its weight column, trains it, and adds its
// weighted term to the partial sum passed down the row.
// ----------------------------------------------------------------------------
module hop_cell #(
    parameter int WEIGHT_BITS = 9,
    parameter int MAX_NEURONS = 64,
    parameter int INDEX       = 0,
    parameter int SUM_W       = 16
) (
    input  logic                           i_clk,
    input  hop_pkg::t_cell_ctl             i_ctl,
    input  logic [$clog2(MAX_NEURONS)-1:0] i_row,
    input  logic                           i_active,
    input  logic                           i_pat_bit,
    input  logic                           i_state_bit,
    input  logic signed [SUM_W-1:0]        i_sum,
    output logic signed [SUM_W-1:0]        o_sum
);
    import hop_pkg::*;

    localparam int AW = $clog2(MAX_NEURONS);
    localparam logic signed [WEIGHT_BITS:0] W_MAX = (WEIGHT_BITS+1)'((1 << (WEIGHT_BITS-1)) - 1);
    localparam logic signed [WEIGHT_BITS:0] W_MIN = -(WEIGHT_BITS+1)'(1 << (WEIGHT_BITS-1));

    logic signed [WEIGHT_BITS-1:0] w_rd;
    logic signed [WEIGHT_BITS-1:0] w_wr;
    logic signed [WEIGHT_BITS:0]   w_ext;
    logic signed [SUM_W-1:0]       w_term;
    logic                          w_diag;
    logic                          w_we;
    logic signed [SUM_W-1:0]       r_sum;

    hop_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(MAX_NEURONS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (i_row),
        .i_wdata (w_wr),
        .i_re    (i_ctl.rd),
        .i_raddr (i_row),
        .o_rdata (w_rd)
    );

    assign w_diag = (i_row == AW'(INDEX));

    // Hebbian step: +1 when row and column agree, -1 otherwise, saturate; clr writes zero
    always_comb begin
        if (i_ctl.row_bit == i_pat_bit) begin
            w_ext = {w_rd[WEIGHT_BITS-1], w_rd} + (WEIGHT_BITS+1)'(1);
        end else begin
            w_ext = {w_rd[WEIGHT_BITS-1], w_rd} - (WEIGHT_BITS+1)'(1);
        end
        if (i_ctl.clr) begin
            w_wr = '0;
        end else if (w_ext > W_MAX) begin
            w_wr = W_MAX[WEIGHT_BITS-1:0];
        end else if (w_ext < W_MIN) begin
            w_wr = W_MIN[WEIGHT_BITS-1:0];
        end else begin
            w_wr = w_ext[WEIGHT_BITS-1:0];
        end
    end

    assign w_we = i_ctl.wr && (i_ctl.clr || (i_active && !w_diag));

    always_comb begin
        if (!i_active) begin
            w_term = '0;
        end else if (i_state_bit) begin
            w_term = SUM_W'(w_rd);
        end else begin
            w_term = -SUM_W'(w_rd);
        end
    end

    // advance the partial sum one cell per cycle
    always_ff @(posedge i_clk) begin
        r_sum <= i_sum + w_term;
    end

    assign o_sum = r_sum;
endmodule

FILE: src/hopfield_associative_memory_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hopfield_associative_memory_core
// Bipolar Hopfield memory with Hebbian training and sequential recall.
// ----------------------------------------------------------------------------
// Usage:
//  i_in carries element items (action, value, new_training_set); o_out
//  carries recalled neuron items. i_cfg_we/i_cfg_data write neuron_count,
//  clamped to 2..MAX_NEURONS, and restart the element fill.
//  new_training_set on a training element first clears the weights. A
//  completed training vector walks the weight rows, reading and then
//  writing each row. A completed probe runs recall: each unit update reads
//  one weight row in every cell and sums it down the cell row; recall ends
//  after n updates without a change. Then n items leave o_out, one per
//  cycle while the receiver takes them. i_in.ready is low while the block
//  trains, recalls or emits; a stalled receiver holds the output register
//  and the emit sequence. Reset (synchronous, active low) runs a clearing
//  pass over all MAX_NEURONS weight rows before items are accepted.
// ----------------------------------------------------------------------------
module hopfield_associative_memory_core #(
    parameter int MAX_NEURONS = 64,
    parameter int WEIGHT_BITS = 9
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [hop_pkg::CFG_W-1:0] i_cfg_data,
    hop_in_if.sink                i_in,
    hop_out_if.source             o_out
);
    import hop_pkg::*;

    localparam int AW    = $clog2(MAX_NEURONS);
    localparam int NW    = AW + 1;
    localparam int SUM_W = WEIGHT_BITS + AW + 1;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CLEAR = 3'd1;
    localparam logic [2:0] S_TRD   = 3'd2;
    localparam logic [2:0] S_TWR   = 3'd3;
    localparam logic [2:0] S_RRD   = 3'd4;
    localparam logic [2:0] S_RSUM  = 3'd5;
    localparam logic [2:0] S_EMIT  = 3'd6;

    logic [2:0]             r_state, n_state;
    logic [CFG_W-1:0]       r_cfg, n_cfg;
    logic [AW-1:0]          r_idx, n_idx;
    logic [AW-1:0]          r_row, n_row;
    logic [NW-1:0]          r_cnt, n_cnt;
    logic [NW-1:0]          r_stable, n_stable;
    logic [ITER_W-1:0]      r_iter, n_iter;
    logic [MAX_NEURONS-1:0] r_pat, n_pat;
    logic [MAX_NEURONS-1:0] r_st, n_st;
    logic                   r_pend, n_pend;
    logic                   r_ov, n_ov;
    logic                   r_onv, n_onv;
    logic                   r_olast, n_olast;
    logic [ITER_W-1:0]      r_oit, n_oit;

    logic [NW-1:0]          w_n;
    logic [MAX_NEURONS-1:0] w_active;
    t_cell_ctl              w_ctl;
    logic signed [SUM_W-1:0] w_chain [MAX_NEURONS+1];
    logic signed [SUM_W-1:0] w_sum;
    logic                   w_acc;
    logic                   w_load;

    // clamp the register to the supported neuron range
    always_comb begin
        if (r_cfg < CFG_W'(2)) begin
            w_n = NW'(2);
        end else if (r_cfg > CFG_W'(MAX_NEURONS)) begin
            w_n = NW'(MAX_NEURONS);
        end else begin
            w_n = r_cfg[NW-1:0];
        end
    end

    always_comb begin
        for (int k = 0; k < MAX_NEURONS; k++) begin
            w_active[k] = (NW'(k) < w_n);
        end
    end

    // cell row: partial sum enters at zero and leaves after the last cell
    assign w_chain[0] = '0;
    for (genvar g = 0; g < MAX_NEURONS; g++) begin : g_cell
        hop_cell #(
            .WEIGHT_BITS (WEIGHT_BITS),
            .MAX_NEURONS (MAX_NEURONS),
            .INDEX       (g),
            .SUM_W       (SUM_W)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl),
            .i_row       (r_row),
            .i_active    (w_active[g]),
            .i_pat_bit   (r_pat[g]),
            .i_state_bit (r_st[g]),
            .i_sum       (w_chain[g]),
            .o_sum       (w_chain[g+1])
        );
    end
    assign w_sum = w_chain[MAX_NEURONS];

    assign i_in.ready       = (r_state == S_IDLE);
    assign w_acc            = i_in.valid && i_in.ready;
    assign o_out.valid        = r_ov;
    assign o_out.neuron_value = r_onv;
    assign o_out.last_of_run  = r_olast;
    assign o_out.iterations   = r_oit;
    assign w_load           = (r_state == S_EMIT) && (!r_ov || o_out.ready);

    always_comb begin
        w_ctl.rd      = (r_state == S_TRD) || (r_state == S_RRD);
        w_ctl.wr      = (r_state == S_TWR) || (r_state == S_CLEAR);
        w_ctl.clr     = (r_state == S_CLEAR);
        w_ctl.row_bit = r_pat[r_row];
    end

    always_comb begin
        n_state  = r_state;
        n_cfg    = r_cfg;
        n_idx    = r_idx;
        n_row    = r_row;
        n_cnt    = r_cnt;
        n_stable = r_stable;
        n_iter   = r_iter;
        n_pat    = r_pat;
        n_st     = r_st;
        n_pend   = r_pend;
        n_ov     = r_ov;
        n_onv    = r_onv;
        n_olast  = r_olast;
        n_oit    = r_oit;

        if (r_ov && o_out.ready) begin
            n_ov = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    if (i_in.action) begin
                        n_st[r_idx] = i_in.value;
                    end else begin
                        n_pat[r_idx] = i_in.value;
                    end
                    n_row = '0;
                    n_pend = 1'b0;
                    if (NW'(r_idx) + NW'(1) < w_n) begin
                        n_idx = r_idx + AW'(1);
                        if (!i_in.action && i_in.new_training_set) begin
                            n_state = S_CLEAR;
                        end
                    end else begin
                        n_idx = '0;
                        if (i_in.action) begin
                            n_iter   = '0;
                            n_stable = '0;
                            n_state  = S_RRD;
                        end else if (i_in.new_training_set) begin
                            n_pend  = 1'b1;
                            n_state = S_CLEAR;
                        end else begin
                            n_state = S_TRD;
                        end
                    end
                end
            end
            S_CLEAR: begin
                n_row = r_row + AW'(1);
                if (r_row == AW'(MAX_NEURONS - 1)) begin
                    n_row   = '0;
                    n_state = r_pend ? S_TRD : S_IDLE;
                end
            end
            S_TRD: begin
                n_state = S_TWR;
            end
            S_TWR: begin
                if (NW'(r_row) + NW'(1) >= w_n) begin
                    n_row   = '0;
                    n_state = S_IDLE;
                end else begin
                    n_row   = r_row + AW'(1);
                    n_state = S_TRD;
                end
            end
            S_RRD: begin
                n_cnt   = '0;
                n_state = S_RSUM;
            end
            S_RSUM: begin
                n_cnt = r_cnt + NW'(1);
                if (r_cnt == NW'(MAX_NEURONS)) begin
                    if (r_iter != '1) begin
                        n_iter = r_iter + ITER_W'(1);
                    end
                    // take the sign; hold the unit on a zero sum
                    if (w_sum > 0 && !r_st[r_row]) begin
                        n_st[r_row] = 1'b1;
                        n_stable    = '0;
                    end else if (w_sum < 0 && r_st[r_row]) begin
                        n_st[r_row] = 1'b0;
                        n_stable    = '0;
                    end else begin
                        n_stable = r_stable + NW'(1);
                    end
                    if (NW'(r_row) + NW'(1) >= w_n) begin
                        n_row = '0;
                    end else begin
                        n_row = r_row + AW'(1);
                    end
                    if (n_stable >= w_n) begin
                        n_row   = '0;
                        n_state = S_EMIT;
                    end else begin
                        n_state = S_RRD;
                    end
                end
            end
            S_EMIT: begin
                if (w_load) begin
                    n_ov    = 1'b1;
                    n_onv   = r_st[r_row];
                    n_olast = (NW'(r_row) + NW'(1) == w_n);
                    n_oit   = r_iter;
                    n_row   = r_row + AW'(1);
                    if (NW'(r_row) + NW'(1) == w_n) begin
                        n_row   = '0;
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (i_cfg_we) begin
            n_cfg = i_cfg_data;
            n_idx = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_cfg    <= CFG_W'(64);
            r_idx    <= '0;
            r_row    <= '0;
            r_cnt    <= '0;
            r_stable <= '0;
            r_iter   <= '0;
            r_pat    <= '0;
            r_st     <= '0;
            r_pend   <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cfg    <= n_cfg;
            r_idx    <= n_idx;
            r_row    <= n_row;
            r_cnt    <= n_cnt;
            r_stable <= n_stable;
            r_iter   <= n_iter;
            r_pat    <= n_pat;
            r_st     <= n_st;
            r_pend   <= n_pend;
            r_ov     <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_onv   <= n_onv;
        r_olast <= n_olast;
        r_oit   <= n_oit;
    end
endmodule

FILE: tb/hop_recall_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hop_recall_checker
// Watches the element, config and neuron channels of the Hopfield core,
// keeps its own copy of weights and neuron vectors, predicts every recalled
// neuron item and compares it field by field.
// ----------------------------------------------------------------------------
module hop_recall_checker #(
    parameter int MAX_NEURONS = 64,
    parameter int WEIGHT_BITS = 9
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [hop_pkg::CFG_W-1:0] i_cfg_data,
    hop_in_if                         in_mon,
    hop_out_if                        out_mon,
    output int                        o_fail_count,
    output int                        o_pending,
    output int                        o_checked
);

    localparam int W_MAX = (1 << (WEIGHT_BITS - 1)) - 1;
    localparam int W_MIN = -(1 << (WEIGHT_BITS - 1));

    typedef struct {
        logic                       neuron_value;
        logic                       last_of_run;
        logic [hop_pkg::ITER_W-1:0] iterations;
    } t_neuron_item;

    int                       weights [0:4095];
    logic [63:0]              train_vec;
    logic [63:0]              neurons;
    int unsigned              fill_idx;
    logic [hop_pkg::CFG_W-1:0] count_reg;
    t_neuron_item             recalled_q[$];

    function automatic int unsigned active_n();
        int unsigned n;
        n = count_reg;
        if (n < 2) n = 2;
        if (n > MAX_NEURONS) n = MAX_NEURONS;
        return n;
    endfunction

    function automatic int bip(logic [63:0] v, int unsigned k);
        return v[k] ? 1 : -1;
    endfunction

    task automatic hebbian_add(int unsigned n);
        int w;
        for (int unsigned r = 0; r < n; r++)
            for (int unsigned c = 0; c < n; c++) begin
                if (r != c) begin
                    w = weights[r * 64 + c] + bip(train_vec, r) * bip(train_vec, c);
                    if (w > W_MAX) w = W_MAX;
                    if (w < W_MIN) w = W_MIN;
                    weights[r * 64 + c] = w;
                end
            end
    endtask

    // Sequential recall; returns the saturating update count.
    task automatic settle(int unsigned n, output logic [31:0] upd);
        int unsigned total;
        int unsigned last_chg;
        int unsigned ptr;
        int          acc;
        total    = 0;
        last_chg = 0;
        ptr      = 0;
        upd      = '0;
        forever begin
            total++;
            if (upd != 32'hFFFF_FFFF) upd++;
            acc = 0;
            for (int unsigned c = 0; c < n; c++)
                acc += weights[ptr * 64 + c] * bip(neurons, c);
            if (acc != 0 && ((acc > 0) != neurons[ptr])) begin
                neurons[ptr] = (acc > 0);
                last_chg = total;
            end
            ptr = (ptr + 1 >= n) ? 0 : ptr + 1;
            if (total - last_chg >= n) break;
        end
    endtask

    task automatic take_element(logic act, logic val, logic nts);
        int unsigned  n;
        logic [31:0]  upd;
        t_neuron_item it;
        n = active_n();
        if (!act) begin
            if (nts) foreach (weights[i]) weights[i] = 0;
            train_vec[fill_idx] = val;
        end else begin
            neurons[fill_idx] = val;
        end
        if (fill_idx + 1 < n) begin
            fill_idx++;
        end else begin
            fill_idx = 0;
            if (!act) begin
                hebbian_add(n);
            end else begin
                settle(n, upd);
                for (int unsigned k = 0; k < n; k++) begin
                    it.neuron_value = neurons[k];
                    it.last_of_run  = (k + 1 == n);
                    it.iterations   = upd;
                    recalled_q = {recalled_q, it};
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_neuron_item exp_it;
        if (!i_rst_n) begin
            foreach (weights[i]) weights[i] = 0;
            train_vec = '0;
            neurons   = '0;
            fill_idx  = 0;
            count_reg = 7'd64;
            recalled_q.delete();
            o_fail_count <= 0;
            o_checked    <= 0;
        end else begin
            if (i_cfg_we) begin
                count_reg = i_cfg_data;
                fill_idx  = 0;
            end
            if (in_mon.valid && in_mon.ready)
                take_element(in_mon.action, in_mon.value, in_mon.new_training_set);
            if (out_mon.valid && out_mon.ready) begin
                o_checked <= o_checked + 1;
                if (recalled_q.size() == 0) begin
                    $error("unexpected neuron item: value %0b last %0b iterations %0d",
                           out_mon.neuron_value, out_mon.last_of_run, out_mon.iterations);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_it = recalled_q.pop_front();
                    if (exp_it.neuron_value !== out_mon.neuron_value ||
                        exp_it.last_of_run !== out_mon.last_of_run ||
                        exp_it.iterations !== out_mon.iterations)
                        o_fail_count <= o_fail_count + 1;
                    if (exp_it.neuron_value !== out_mon.neuron_value)
                        $error("neuron_value: expected %0b actual %0b",
                               exp_it.neuron_value, out_mon.neuron_value);
                    if (exp_it.last_of_run !== out_mon.last_of_run)
                        $error("last_of_run: expected %0b actual %0b",
                               exp_it.last_of_run, out_mon.last_of_run);
                    if (exp_it.iterations !== out_mon.iterations)
                        $error("iterations: expected %0d actual %0d",
                               exp_it.iterations, out_mon.iterations);
                end
            end
        end
        o_pending <= recalled_q.size();
    end

endmodule

FILE: tb/tb_hopfield_associative_memory_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hopfield_associative_memory_core
// Drives training and probe vectors into the Hopfield core under random
// sender bursts and receiver stalls; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_hopfield_associative_memory_core;

    localparam int MAX_N      = 64;
    localparam int W_BITS     = 9;
    localparam int RAND_ITEMS = 480;
    localparam int LIMIT      = 2_000_000;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_cfg_we = 1'b0;
    logic [hop_pkg::CFG_W-1:0] i_cfg_data = '0;

    hop_in_if  in_if ();
    hop_out_if out_if ();

    int fail_count;
    int pending;
    int checked;
    int sent_items = 0;
    int cycle_cnt = 0;
    int burst_left = 0;
    int n_cur = 64;
    int phases = 0;

    // Patterns stored in the current training set, used to build probes.
    logic [63:0] stored_q[$];

    hopfield_associative_memory_core #(
        .MAX_NEURONS(MAX_N),
        .WEIGHT_BITS(W_BITS)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    hop_recall_checker #(
        .MAX_NEURONS(MAX_N),
        .WEIGHT_BITS(W_BITS)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .in_mon       (in_if),
        .out_mon      (out_if),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    initial begin
        in_if.valid            = 1'b0;
        in_if.action           = 1'b0;
        in_if.value            = 1'b0;
        in_if.new_training_set = 1'b0;
        out_if.ready           = 1'b0;
    end

    // Timeout: hold a cycle count and drop the run if it never drains.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > LIMIT) begin
            $display("hopfield_associative_memory_core regression: fail");
            $finish;
        end
    end

    // Receiver: switch at random between always-ready, coin-flip, periodic and
    // mostly-stalled modes so stalls land on many different emit phases.
    int stall_mode = 0;
    always @(posedge i_clk) begin
        if (cycle_cnt % 300 == 0) stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0:       out_if.ready <= 1'b1;
            1:       out_if.ready <= 1'($urandom_range(0, 1));
            2:       out_if.ready <= (cycle_cnt % 5 != 0);
            default: out_if.ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // Send one element and hold it until the block takes it. Valid stays
    // high across a burst and drops in the gaps between bursts.
    task automatic send_element(logic act, logic val, logic nts);
        if (burst_left == 0) begin
            if (in_if.valid) begin
                in_if.valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        in_if.valid            <= 1'b1;
        in_if.action           <= act;
        in_if.value            <= val;
        in_if.new_training_set <= nts;
        do @(posedge i_clk); while (!in_if.ready);
        sent_items++;
    endtask

    // Drain: drop valid, wait for all expected items and for the block to
    // come back ready (training and clearing take a while with no output).
    task automatic wait_idle();
        if (in_if.valid) in_if.valid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (pending != 0 || !in_if.ready) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_count(logic [hop_pkg::CFG_W-1:0] raw);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= raw;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        @(posedge i_clk);
        n_cur = (raw < 2) ? 2 : ((raw > MAX_N) ? MAX_N : raw);
    endtask

    task automatic send_vector(logic act, logic [63:0] bits, logic clear_first);
        for (int k = 0; k < n_cur; k++)
            send_element(act, bits[k], (k == 0) ? clear_first : 1'b0);
    endtask

    function automatic logic [63:0] rand_bits();
        return {$urandom(), $urandom()};
    endfunction

    initial begin
        logic [63:0] pat;
        logic [63:0] probe;
        int          pick;
        int          raw;
        int          n_pat;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait_idle();

        // ---- directed: two-neuron corner cases ----
        write_count(7'd1);                      // below range, used as 2
        send_vector(1'b1, 64'b10, 1'b0);        // probe with all-zero weights
        send_vector(1'b0, 64'b11, 1'b1);        // store (+,+)
        send_vector(1'b1, 64'b01, 1'b0);        // one unit flips
        send_vector(1'b1, 64'b00, 1'b0);        // all low: already stable
        send_element(1'b0, 1'b1, 1'b0);         // mixed vector, probe closes it
        send_element(1'b1, 1'b0, 1'b1);         // new-set flag on probe ignored
        send_vector(1'b0, 64'b01, 1'b1);        // clear then store (+,-)
        send_vector(1'b1, 64'b11, 1'b0);
        wait_idle();
        write_count(7'd3);
        send_element(1'b0, 1'b1, 1'b0);         // partial vector, then restart
        wait_idle();
        write_count(7'd0);                      // zero also maps to 2
        send_vector(1'b1, 64'b10, 1'b0);
        wait_idle();

        // ---- weight saturation at both ends of the range ----
        send_vector(1'b0, 64'b11, 1'b1);
        repeat ((1 << (W_BITS - 1)) + 2) send_vector(1'b0, 64'b11, 1'b0);
        send_vector(1'b1, 64'b01, 1'b0);
        send_vector(1'b0, 64'b01, 1'b1);
        repeat ((1 << (W_BITS - 1)) + 2) send_vector(1'b0, 64'b10, 1'b0);
        send_vector(1'b1, 64'b11, 1'b0);
        wait_idle();

        // ---- random phases: train a small set, probe with noisy copies ----
        sent_items = 0;
        while (sent_items < RAND_ITEMS) begin
            phases++;
            pick = $urandom_range(0, 11);
            if (pick == 0 && phases % 4 == 1) raw = ($urandom_range(0, 1)) ? 127 : 64;
            else if (pick == 1) raw = $urandom_range(0, 2);
            else if (pick == 2) raw = $urandom_range(65, 127);
            else raw = $urandom_range(3, 12);
            if (raw > MAX_N && pick != 0 && pick != 2) raw = 12;
            write_count(raw[hop_pkg::CFG_W-1:0]);
            if (pick == 2) n_cur = $urandom_range(3, 12);
            if (pick == 2) write_count(n_cur[hop_pkg::CFG_W-1:0]);

            stored_q.delete();
            n_pat = (n_cur == MAX_N) ? 1 : $urandom_range(1, 3);
            for (int p = 0; p < n_pat; p++) begin
                pat = rand_bits();
                stored_q = {stored_q, pat};
                send_vector(1'b0, pat, (p == 0) ? ($urandom_range(0, 4) != 0) : 1'b0);
            end
            repeat ((n_cur == MAX_N) ? 1 : $urandom_range(1, 4)) begin
                probe = stored_q[$urandom_range(0, stored_q.size() - 1)];
                repeat ($urandom_range(0, 2)) probe[$urandom_range(0, n_cur - 1)] ^= 1'b1;
                send_vector(1'b1, probe, 1'b0);
            end
            // Noise: a vector of random kinds and flags.
            if (n_cur < MAX_N && $urandom_range(0, 2) == 0)
                for (int k = 0; k < n_cur; k++)
                    send_element(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                 ($urandom_range(0, 5) == 0));
            // Occasionally leave a vector half filled before the next write.
            if ($urandom_range(0, 4) == 0)
                send_element(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b0);
            wait_idle();
        end

        repeat (MAX_N + 20) @(posedge i_clk);
        $display("covered %0d random phases and %0d random elements; %0d neuron items checked",
                 phases, sent_items, checked);
        if (fail_count == 0 && pending == 0) begin
            $display("hopfield_associative_memory_core regression: pass");
        end else begin
            if (pending != 0) $error("%0d expected neuron items never arrived", pending);
            $display("hopfield_associative_memory_core regression: fail");
        end
        $finish;
    end

endmodule

FILE: files.f
src/hop_pkg.sv
src/hop_if.sv
src/hop_ram.sv
src/hop_cell.sv
src/hopfield_associative_memory_core.sv
tb/hop_recall_checker.sv
tb/tb_hopfield_associative_memory_core.sv
